// ----- sv/video_interface_register_block_core_defines.svh -----
// Shared assertion macros for the video interface register block.
// Both expect signals named clk and rst_n in the using scope.
`ifndef VIDEO_INTERFACE_REGISTER_BLOCK_CORE_DEFINES_SVH
`define VIDEO_INTERFACE_REGISTER_BLOCK_CORE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define VIR_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define VIR_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/vir_pkg.sv -----
package vir_pkg;

    // Default geometry of the register space
    localparam int REG_BYTES_DEF        = 256;
    localparam int NUM_DISPLAY_INTS_DEF = 4;
    localparam int DISPLAY_INT_BASE_DEF = 48;
    localparam int TOP_FB_OFFSET_DEF    = 28;
    localparam int BOTTOM_FB_OFFSET_DEF = 36;
    localparam int BEAM_OFFSET_DEF      = 44;

    // Byte lanes of the register file and width of a byte address
    localparam int LANES  = 4;
    localparam int ADDR_W = 17;

    // Request kinds
    localparam logic [1:0] KIND_READ  = 2'd0;
    localparam logic [1:0] KIND_WRITE = 2'd1;
    localparam logic [1:0] KIND_TICK  = 2'd2;

    // Register layout and reset image
    localparam int          TIMING_AT     = 0;
    localparam int          CONTROL_AT    = 2;
    localparam logic [15:0] TIMING_RESET  = 16'h0006;
    localparam logic [15:0] CONTROL_RESET = 16'h0001;
    localparam logic [31:0] DI_RESET      = 32'h1107_01AE;

    // Bit positions inside a 32-bit register
    localparam int FLAG_BIT = 31;
    localparam int PAGE_BIT = 28;
    localparam int MASK_BIT = 28;

    // Field timing
    localparam logic [9:0] LINES_PAL  = 10'd313;
    localparam logic [9:0] LINES_NTSC = 10'd263;
    localparam logic [1:0] FMT_PAL    = 2'd1;
    localparam int         FB_BASE_W  = 24;
    localparam int         FB_SHIFT   = 5;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] offset;
        logic [2:0]  access_bytes;
        logic [31:0] write_data;
    } vir_req_t;

    typedef struct packed {
        logic [31:0] read_data;
        logic        irq_pending;
        logic        field_is_top;
        logic [63:0] fields_elapsed;
        logic [28:0] scan_address;
        logic [28:0] top_address;
        logic [28:0] bottom_address;
    } vir_rsp_t;

    // Status after a request, handed from the register overlay to the top
    typedef struct packed {
        logic        irq_pending;
        logic        field_is_top;
        logic [63:0] fields_elapsed;
        logic [28:0] scan_address;
        logic [28:0] top_address;
        logic [28:0] bottom_address;
    } vir_status_t;

    // Number of bytes an access covers: 1, 2, else 4
    function automatic logic [2:0] access_len(input logic [2:0] nb);
        logic [2:0] n;
        unique case (nb)
            3'd1:    n = 3'd1;
            3'd2:    n = 3'd2;
            default: n = 3'd4;
        endcase
        return n;
    endfunction

    // Big-endian byte k of a write of the given size
    function automatic logic [7:0] write_byte(input logic [31:0] wd, input logic [2:0] nb,
                                              input logic [1:0] k);
        logic [7:0] b;
        unique case (nb)
            3'd1:    b = wd[7:0];
            3'd2:    b = k[0] ? wd[7:0] : wd[15:8];
            default: b = wd[{~k, 3'b000} +: 8];
        endcase
        return b;
    endfunction

    // Address of the byte of a 4-byte window at off that falls in lane b
    function automatic logic [ADDR_W-1:0] lane_addr(input logic [15:0] off,
                                                    input logic [1:0] b);
        logic [1:0] rot;
        rot = b - off[1:0];
        return {1'b0, off} + ADDR_W'(rot);
    endfunction

endpackage

// ----- sv/vir_ram.sv -----
module vir_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port, one registered read port; read returns old data on collision
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ----- sv/vir_regs.sv -----
`include "video_interface_register_block_core_defines.svh"

module vir_regs #(
    parameter int REG_BYTES        = vir_pkg::REG_BYTES_DEF,
    parameter int NUM_DISPLAY_INTS = vir_pkg::NUM_DISPLAY_INTS_DEF,
    parameter int DISPLAY_INT_BASE = vir_pkg::DISPLAY_INT_BASE_DEF,
    parameter int TOP_FB_OFFSET    = vir_pkg::TOP_FB_OFFSET_DEF,
    parameter int BOTTOM_FB_OFFSET = vir_pkg::BOTTOM_FB_OFFSET_DEF,
    parameter int BEAM_OFFSET      = vir_pkg::BEAM_OFFSET_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        apply,
    input  vir_pkg::vir_req_t           req,
    input  logic [vir_pkg::ADDR_W-1:0]  lane_rd_addr [vir_pkg::LANES],
    output logic [vir_pkg::LANES-1:0]   lane_hit,
    output logic [7:0]                  lane_byte [vir_pkg::LANES],
    output vir_pkg::vir_status_t        status_next
);

    import vir_pkg::*;

    // Slot layout of the flop overlay
    localparam int SLOT_TIMING  = 0;
    localparam int SLOT_CONTROL = 2;
    localparam int SLOT_TOP     = 4;
    localparam int SLOT_BOT     = 8;
    localparam int SLOT_BEAM    = 12;
    localparam int SLOT_INT     = 14;
    localparam int NSLOT        = SLOT_INT + 4 * NUM_DISPLAY_INTS;

    localparam logic [ADDR_W-1:0] REG_END = ADDR_W'(REG_BYTES);
    localparam logic [ADDR_W-1:0] TOP_AT  = ADDR_W'(TOP_FB_OFFSET);
    localparam logic [ADDR_W-1:0] BEAM_AT = ADDR_W'(BEAM_OFFSET);

    // Byte address held by slot j
    function automatic int slot_addr(input int j);
        int a;
        if (j < SLOT_TOP)
            a = TIMING_AT + j;
        else if (j < SLOT_BOT)
            a = TOP_FB_OFFSET + j - SLOT_TOP;
        else if (j < SLOT_BEAM)
            a = BOTTOM_FB_OFFSET + j - SLOT_BOT;
        else if (j < SLOT_INT)
            a = BEAM_OFFSET + j - SLOT_BEAM;
        else
            a = DISPLAY_INT_BASE + j - SLOT_INT;
        return a;
    endfunction

    // Reset image of one byte; the first display interrupt word is laid down last
    function automatic logic [7:0] reset_byte(input int a);
        logic [7:0] v;
        if (a >= REG_BYTES)
            v = 8'h00;
        else if (a >= DISPLAY_INT_BASE && a < DISPLAY_INT_BASE + 4)
            v = DI_RESET[8 * (3 - (a - DISPLAY_INT_BASE)) +: 8];
        else if (a < CONTROL_AT)
            v = TIMING_RESET[8 * (CONTROL_AT - 1 - a) +: 8];
        else if (a < CONTROL_AT + 2)
            v = CONTROL_RESET[8 * (CONTROL_AT + 1 - a) +: 8];
        else
            v = 8'h00;
        return v;
    endfunction

    logic [NSLOT-1:0][7:0] hot_reg;
    logic [NSLOT-1:0][7:0] p1_byte;
    logic [NSLOT-1:0][7:0] hot_next;
    logic                  top_flag_reg;
    logic                  top_flag_next;
    logic [63:0]           cnt_reg;
    logic [63:0]           cnt_next;

    logic                  off_in;
    logic                  do_write;
    logic                  do_fix;
    logic                  do_tick;
    logic [2:0]            len;
    logic [15:0]           timing16;
    logic [9:0]            acv;
    logic [9:0]            lines;
    logic [31:0]           int_word [NUM_DISPLAY_INTS];
    logic [NUM_DISPLAY_INTS-1:0] int_latch;
    logic [31:0]           top_word;
    logic [31:0]           bot_word;
    logic [28:0]           top_addr;
    logic [28:0]           bot_addr;
    logic                  irq_any;

    assign off_in   = {1'b0, req.offset} < REG_END;
    assign do_write = (req.kind == KIND_WRITE) && off_in;
    assign do_tick  = (req.kind == KIND_TICK);
    assign len      = access_len(req.access_bytes);

    // Lines per field from the timing register or the video format
    assign timing16 = {hot_reg[SLOT_TIMING], hot_reg[SLOT_TIMING + 1]};
    assign acv      = timing16[13:4];
    assign lines    = (acv != 10'd0) ? acv :
                      ((hot_reg[SLOT_CONTROL][1:0] == FMT_PAL) ? LINES_PAL : LINES_NTSC);

    // Display interrupts that latch on this tick
    always_comb
    begin
        for (int i = 0; i < NUM_DISPLAY_INTS; i++)
        begin
            int_word[i]  = {hot_reg[SLOT_INT + 4 * i], hot_reg[SLOT_INT + 4 * i + 1],
                            hot_reg[SLOT_INT + 4 * i + 2], hot_reg[SLOT_INT + 4 * i + 3]};
            int_latch[i] = int_word[i][MASK_BIT] && (int_word[i][26:16] <= {1'b0, lines});
        end
    end

    // Bus write into every slot the access covers
    always_comb
    begin
        logic [ADDR_W-1:0] sa;
        logic [ADDR_W-1:0] delta;
        for (int j = 0; j < NSLOT; j++)
        begin
            sa         = ADDR_W'(slot_addr(j));
            delta      = sa - {1'b0, req.offset};
            p1_byte[j] = hot_reg[j];
            if (do_write && (sa < REG_END) && ({1'b0, req.offset} <= sa) &&
                (delta < ADDR_W'(len)))
            begin
                p1_byte[j] = write_byte(req.write_data, req.access_bytes, delta[1:0]);
            end
        end
    end

    // Writing the top word with its flag set drops the page-offset bit
    assign do_fix = do_write && (req.offset == 16'(TOP_FB_OFFSET)) &&
                    p1_byte[SLOT_TOP][FLAG_BIT - 24];

    // Top-word fix, interrupt latch, beam update and zeroing past the register end
    always_comb
    begin
        logic [ADDR_W-1:0] sa;
        for (int j = 0; j < NSLOT; j++)
        begin
            sa          = ADDR_W'(slot_addr(j));
            hot_next[j] = p1_byte[j];
            if (do_fix && (sa == TOP_AT))
            begin
                hot_next[j][PAGE_BIT - 24] = 1'b0;
            end
            if (do_tick)
            begin
                for (int i = 0; i < NUM_DISPLAY_INTS; i++)
                begin
                    if (int_latch[i] && (sa == ADDR_W'(DISPLAY_INT_BASE + 4 * i)))
                    begin
                        hot_next[j][FLAG_BIT - 24] = 1'b1;
                    end
                end
                if (sa == BEAM_AT)
                begin
                    hot_next[j] = {6'b0, lines[9:8]};
                end
                if (sa == BEAM_AT + ADDR_W'(1))
                begin
                    hot_next[j] = lines[7:0];
                end
            end
            if (sa >= REG_END)
            begin
                hot_next[j] = 8'h00;
            end
        end
    end

    assign top_flag_next = top_flag_reg ^ do_tick;
    assign cnt_next      = cnt_reg + {63'd0, do_tick};

    // Frame buffer addresses and interrupt summary after the request
    assign top_word = {hot_next[SLOT_TOP], hot_next[SLOT_TOP + 1],
                       hot_next[SLOT_TOP + 2], hot_next[SLOT_TOP + 3]};
    assign bot_word = {hot_next[SLOT_BOT], hot_next[SLOT_BOT + 1],
                       hot_next[SLOT_BOT + 2], hot_next[SLOT_BOT + 3]};
    assign top_addr = top_word[PAGE_BIT] ? {top_word[FB_BASE_W-1:0], FB_SHIFT'(0)}
                                         : {FB_SHIFT'(0), top_word[FB_BASE_W-1:0]};
    assign bot_addr = top_word[PAGE_BIT] ? {bot_word[FB_BASE_W-1:0], FB_SHIFT'(0)}
                                         : {FB_SHIFT'(0), bot_word[FB_BASE_W-1:0]};

    always_comb
    begin
        logic [31:0] w;
        irq_any = 1'b0;
        for (int i = 0; i < NUM_DISPLAY_INTS; i++)
        begin
            w = {hot_next[SLOT_INT + 4 * i], hot_next[SLOT_INT + 4 * i + 1],
                 hot_next[SLOT_INT + 4 * i + 2], hot_next[SLOT_INT + 4 * i + 3]};
            irq_any = irq_any | (w[FLAG_BIT] & w[MASK_BIT]);
        end
    end

    always_comb
    begin
        status_next.irq_pending    = irq_any;
        status_next.field_is_top   = top_flag_next;
        status_next.fields_elapsed = cnt_next;
        status_next.top_address    = top_addr;
        status_next.bottom_address = bot_addr;
        status_next.scan_address   = (!top_flag_next && (bot_addr != 29'd0)) ? bot_addr
                                                                             : top_addr;
    end

    // Read lookup of the overlay for each lane of the bus window
    always_comb
    begin
        for (int k = 0; k < LANES; k++)
        begin
            lane_hit[k]  = 1'b0;
            lane_byte[k] = 8'h00;
            for (int j = 0; j < NSLOT; j++)
            begin
                if ((ADDR_W'(slot_addr(j)) < REG_END) &&
                    (lane_rd_addr[k] == ADDR_W'(slot_addr(j))))
                begin
                    lane_hit[k]  = 1'b1;
                    lane_byte[k] = lane_byte[k] | hot_reg[j];
                end
            end
        end
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int j = 0; j < NSLOT; j++)
            begin
                hot_reg[j] <= reset_byte(slot_addr(j));
            end
            top_flag_reg <= 1'b1;
            cnt_reg      <= 64'd0;
        end
        else if (apply)
        begin
            hot_reg      <= hot_next;
            top_flag_reg <= top_flag_next;
            cnt_reg      <= cnt_next;
        end
    end

    `VIR_ASSERT_NXT(a_tick_advances, apply && (req.kind == KIND_TICK), (cnt_reg == $past(cnt_reg) + 64'd1) && (top_flag_reg != $past(top_flag_reg)), "tick did not advance field state")
    `VIR_ASSERT_NXT(a_field_holds, !(apply && (req.kind == KIND_TICK)), $stable(cnt_reg) && $stable(top_flag_reg), "field state moved without a tick")
    `VIR_ASSERT_NXT(a_read_no_change, apply && (req.kind == KIND_READ), $stable(hot_reg), "read changed a register")

endmodule

// ----- sv/video_interface_register_block_core.sv -----
// Channel   Direction  Handshake               Payload
// req       in         req_valid / req_ready   vir_req_t (kind, offset, size, data)
// rsp       out        rsp_valid / rsp_ready   vir_rsp_t (read data and status)
//
// One request per clock unless stalled; its result is registered after the input stage.
// Storage is four byte-lane RAMs with one registered read each, so any 1-4 byte
// window is fetched in one access; the timing, frame buffer, beam and interrupt
// registers sit in flops beside them.
// Reset clears field state and RAM valid bits at once; no clearing pass.
// A stalled result holds the input stage; a new request is taken whenever the
// input stage is empty or moving into a free or draining result register.
`include "video_interface_register_block_core_defines.svh"

module video_interface_register_block_core #(
    parameter int REG_BYTES        = vir_pkg::REG_BYTES_DEF,
    parameter int NUM_DISPLAY_INTS = vir_pkg::NUM_DISPLAY_INTS_DEF,
    parameter int DISPLAY_INT_BASE = vir_pkg::DISPLAY_INT_BASE_DEF,
    parameter int TOP_FB_OFFSET    = vir_pkg::TOP_FB_OFFSET_DEF,
    parameter int BOTTOM_FB_OFFSET = vir_pkg::BOTTOM_FB_OFFSET_DEF,
    parameter int BEAM_OFFSET      = vir_pkg::BEAM_OFFSET_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_ready,
    input  vir_pkg::vir_req_t req,
    output logic              rsp_valid,
    input  logic              rsp_ready,
    output vir_pkg::vir_rsp_t rsp
);

    import vir_pkg::*;

    localparam int BANK_DEPTH = (REG_BYTES + LANES - 1) / LANES;
    localparam int IDX_W      = $clog2(BANK_DEPTH);
    localparam logic [ADDR_W-1:0] REG_END = ADDR_W'(REG_BYTES);

    logic        s1_valid_reg;
    vir_req_t    s1_req_reg;
    logic        rsp_valid_reg;
    vir_rsp_t    rsp_reg;
    logic        advance;
    logic        accept;
    logic        off_in;
    logic [2:0]  len;

    logic [ADDR_W-1:0] rd_bank_addr [LANES];
    logic [ADDR_W-1:0] s1_bank_addr [LANES];
    logic [IDX_W-1:0]  s1_idx       [LANES];
    logic [1:0]        s1_rot       [LANES];
    logic [LANES-1:0]  bank_we;
    logic [7:0]        bank_wdata   [LANES];
    logic [7:0]        bank_rdata   [LANES];
    logic [7:0]        bank_byte    [LANES];

    logic [LANES-1:0]     fwd_en_reg;
    logic [IDX_W-1:0]     fwd_idx_reg  [LANES];
    logic [7:0]           fwd_data_reg [LANES];
    logic [BANK_DEPTH-1:0] valid_reg   [LANES];

    logic [ADDR_W-1:0] win_addr [LANES];
    logic [LANES-1:0]  hot_hit;
    logic [7:0]        hot_byte [LANES];
    logic [7:0]        rd_byte  [LANES];
    logic [31:0]       rd_word;
    logic [31:0]       read_data;
    vir_status_t       status_next;

    // Flow control: one input stage, one result register
    assign advance   = s1_valid_reg && (!rsp_valid_reg || rsp_ready);
    assign req_ready = !s1_valid_reg || advance;
    assign accept    = req_valid && req_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (req_ready)
        begin
            s1_valid_reg <= req_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_req_reg <= req;
        end
    end

    assign off_in = {1'b0, s1_req_reg.offset} < REG_END;
    assign len    = access_len(s1_req_reg.access_bytes);

    // Byte-lane RAMs: read issued on acceptance, write when the request retires
    for (genvar b = 0; b < LANES; b++)
    begin : g_bank
        assign rd_bank_addr[b] = lane_addr(req.offset, 2'(b));
        assign s1_bank_addr[b] = lane_addr(s1_req_reg.offset, 2'(b));
        assign s1_idx[b]       = s1_bank_addr[b][2 +: IDX_W];
        assign s1_rot[b]       = 2'(b) - s1_req_reg.offset[1:0];
        assign bank_we[b]      = advance && (s1_req_reg.kind == KIND_WRITE) && off_in &&
                                 ({1'b0, s1_rot[b]} < len) && (s1_bank_addr[b] < REG_END);
        assign bank_wdata[b]   = write_byte(s1_req_reg.write_data, s1_req_reg.access_bytes,
                                            s1_rot[b]);

        vir_ram #(
            .WIDTH (8),
            .DEPTH (BANK_DEPTH)
        ) u_ram (
            .clk     (clk),
            .wr_en   (bank_we[b]),
            .wr_addr (s1_idx[b]),
            .wr_data (bank_wdata[b]),
            .rd_en   (accept),
            .rd_addr (rd_bank_addr[b][2 +: IDX_W]),
            .rd_data (bank_rdata[b])
        );

        // Unwritten entries read as zero; the write retiring on the read edge is forwarded
        assign bank_byte[b] = !valid_reg[b][s1_idx[b]] ? 8'h00 :
                              (fwd_en_reg[b] && (fwd_idx_reg[b] == s1_idx[b])) ?
                              fwd_data_reg[b] : bank_rdata[b];
    end

    // Valid bits and forwarding registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_en_reg <= '0;
            for (int b = 0; b < LANES; b++)
            begin
                valid_reg[b] <= '0;
            end
        end
        else if (advance)
        begin
            fwd_en_reg <= bank_we;
            for (int b = 0; b < LANES; b++)
            begin
                if (bank_we[b])
                begin
                    valid_reg[b][s1_idx[b]] <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            for (int b = 0; b < LANES; b++)
            begin
                fwd_idx_reg[b]  <= s1_idx[b];
                fwd_data_reg[b] <= bank_wdata[b];
            end
        end
    end

    // Flop-held registers and field state
    always_comb
    begin
        for (int k = 0; k < LANES; k++)
        begin
            win_addr[k] = {1'b0, s1_req_reg.offset} + ADDR_W'(k);
        end
    end

    vir_regs #(
        .REG_BYTES        (REG_BYTES),
        .NUM_DISPLAY_INTS (NUM_DISPLAY_INTS),
        .DISPLAY_INT_BASE (DISPLAY_INT_BASE),
        .TOP_FB_OFFSET    (TOP_FB_OFFSET),
        .BOTTOM_FB_OFFSET (BOTTOM_FB_OFFSET),
        .BEAM_OFFSET      (BEAM_OFFSET)
    ) u_regs (
        .clk          (clk),
        .rst_n        (rst_n),
        .apply        (advance),
        .req          (s1_req_reg),
        .lane_rd_addr (win_addr),
        .lane_hit     (hot_hit),
        .lane_byte    (hot_byte),
        .status_next  (status_next)
    );

    // Read bytes in access order, overlay first, zero past the end
    always_comb
    begin
        for (int k = 0; k < LANES; k++)
        begin
            if ((win_addr[k] < REG_END) && (3'(k) < len))
                rd_byte[k] = hot_hit[k] ? hot_byte[k] : bank_byte[win_addr[k][1:0]];
            else
                rd_byte[k] = 8'h00;
        end
    end

    always_comb
    begin
        unique case (s1_req_reg.access_bytes)
            3'd1:    rd_word = {24'd0, rd_byte[0]};
            3'd2:    rd_word = {16'd0, rd_byte[0], rd_byte[1]};
            default: rd_word = {rd_byte[0], rd_byte[1], rd_byte[2], rd_byte[3]};
        endcase
    end

    assign read_data = ((s1_req_reg.kind == KIND_READ) && off_in) ? rd_word : 32'd0;

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            rsp_reg.read_data      <= read_data;
            rsp_reg.irq_pending    <= status_next.irq_pending;
            rsp_reg.field_is_top   <= status_next.field_is_top;
            rsp_reg.fields_elapsed <= status_next.fields_elapsed;
            rsp_reg.scan_address   <= status_next.scan_address;
            rsp_reg.top_address    <= status_next.top_address;
            rsp_reg.bottom_address <= status_next.bottom_address;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    `VIR_ASSERT_NXT(a_nonread_zero, advance && (s1_req_reg.kind != KIND_READ), rsp.read_data == 32'd0, "non-read request returned data")
    `VIR_ASSERT_NXT(a_oob_read_zero, advance && !off_in, rsp.read_data == 32'd0, "out-of-range read returned data")
    `VIR_ASSERT_IMP(a_stall_blocks, s1_valid_reg && rsp_valid_reg && !rsp_ready, !req_ready, "request taken while result stalled")

endmodule
